// ----- rtl/core/i128d_pkg.sv -----
// Shared types and constants for the 128-bit integer divider.
`default_nettype none

package i128d_pkg;

    localparam int unsigned WORD_W     = 128;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned STEP_COUNT = 128;

    // Mode codes: bit 1 selects signed operands, bit 0 selects the remainder.
    typedef enum logic [1:0] {
        MODE_UDIV = 2'd0,
        MODE_UREM = 2'd1,
        MODE_SDIV = 2'd2,
        MODE_SREM = 2'd3
    } i128d_mode_t;

    // Per-item state that travels down the divide pipeline.
    typedef struct packed {
        logic [WORD_W-1:0] rem;      // partial remainder
        logic [WORD_W-1:0] nq;       // dividend bits out at the top, quotient bits in at the bottom
        logic [WORD_W-1:0] den;      // divisor magnitude
        logic              want_rem;
        logic              neg_res;  // negate the selected result
        logic              dz;
    } i128d_work_t;

endpackage

`default_nettype wire

// ----- rtl/core/i128d_ifs.sv -----
// Request and response channel interfaces of the 128-bit integer divider.
`default_nettype none

interface i128d_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] dividend_hi;
    logic [63:0] dividend_lo;
    logic [63:0] divisor_hi;
    logic [63:0] divisor_lo;

    modport source (
        output valid, mode, dividend_hi, dividend_lo, divisor_hi, divisor_lo,
        input  ready
    );
    modport sink (
        input  valid, mode, dividend_hi, dividend_lo, divisor_hi, divisor_lo,
        output ready
    );
endinterface

interface i128d_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic        divide_by_zero;

    modport source (
        output valid, result_hi, result_lo, divide_by_zero,
        input  ready
    );
    modport sink (
        input  valid, result_hi, result_lo, divide_by_zero,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/int128_divider_unit.sv -----
// Top level of the pipelined 128-bit signed/unsigned integer divider.
`default_nettype none

// The divider accepts one item per clock cycle while req.ready is high and returns
// one result per item in order, passing through one operand stage that takes the
// magnitudes of signed operands, then 128 restoring-division
// stages that each resolve one quotient bit with a 129-bit compare and subtract,
// and one result stage that picks quotient or remainder, applies the sign and
// registers it. Modes: 0 unsigned quotient, 1 unsigned remainder, 2 signed
// quotient, 3 signed remainder. Signed quotients are negated when the operand
// signs differ and signed remainders take the dividend's sign; the most negative
// value divided by minus one wraps to itself with remainder zero. A zero divisor
// raises divide_by_zero and yields an all-ones magnitude quotient and the
// dividend's magnitude as remainder, sign rules applied as usual. The output
// has a one-entry skid slot: while a result waits to be taken the pipeline keeps
// moving for one more item, and req.ready drops only once that slot is full, so
// a stall on the response side loses and repeats nothing.
module int128_divider_unit
    import i128d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    i128d_req_if.sink     req,
    i128d_rsp_if.source   rsp
);

    logic                advance;
    logic [STEP_COUNT:0] stage_valid;
    i128d_work_t         stage_work [STEP_COUNT+1];

    // Operand stage feeds stage 0.
    i128d_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req),
        .valid   (stage_valid[0]),
        .work    (stage_work[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < STEP_COUNT; k++)
    begin : g_step
        i128d_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (stage_valid[k]),
            .prev_work  (stage_work[k]),
            .valid      (stage_valid[k+1]),
            .work       (stage_work[k+1])
        );
    end

    // Sign correction, output register and skid slot; drives the pipeline hold.
    i128d_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (stage_valid[STEP_COUNT]),
        .tail_work  (stage_work[STEP_COUNT]),
        .advance    (advance),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/core/i128d_prep.sv -----
// Operand stage: takes magnitudes of signed operands and loads the pipeline.
`default_nettype none

module i128d_prep
    import i128d_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    i128d_req_if.sink   req,
    output logic        valid,
    output i128d_work_t work
);

    logic              valid_reg;
    logic              valid_next;
    i128d_work_t       work_reg;
    i128d_work_t       work_next;
    logic              is_signed;
    logic              n_neg;
    logic              d_neg;
    logic [WORD_W-1:0] n_raw;
    logic [WORD_W-1:0] d_raw;

    assign req.ready = advance;

    always_comb
    begin
        is_signed = req.mode[1];
        n_raw     = {req.dividend_hi, req.dividend_lo};
        d_raw     = {req.divisor_hi, req.divisor_lo};
        n_neg     = is_signed & n_raw[WORD_W-1];
        d_neg     = is_signed & d_raw[WORD_W-1];

        work_next.rem      = '0;
        work_next.nq       = n_neg ? (~n_raw + {{(WORD_W-1){1'b0}}, 1'b1}) : n_raw;
        work_next.den      = d_neg ? (~d_raw + {{(WORD_W-1){1'b0}}, 1'b1}) : d_raw;
        work_next.want_rem = req.mode[0];
        work_next.neg_res  = req.mode[0] ? n_neg : (n_neg ^ d_neg);
        work_next.dz       = (d_raw == '0);
        valid_next         = req.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads whenever the pipeline moves; bubbles carry don't-care data.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    assign valid = valid_reg;
    assign work  = work_reg;

endmodule

`default_nettype wire

// ----- rtl/core/i128d_step.sv -----
// One restoring-division stage: shift in a dividend bit, compare, subtract.
`default_nettype none

module i128d_step
    import i128d_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic         prev_valid,
    input  wire i128d_work_t  prev_work,
    output logic              valid,
    output i128d_work_t       work
);

    logic            valid_reg;
    i128d_work_t     work_reg;
    i128d_work_t     work_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;
    logic              ge;

    always_comb
    begin
        // 129-bit partial remainder: the shifted-out top bit is kept, so large
        // divisors compare correctly.
        shifted = {prev_work.rem, prev_work.nq[WORD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, prev_work.den};
        ge      = ~diff[WORD_W+1];

        work_next     = prev_work;
        work_next.rem = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        work_next.nq  = {prev_work.nq[WORD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    assign valid = valid_reg;
    assign work  = work_reg;

endmodule

`default_nettype wire

// ----- rtl/core/i128d_post.sv -----
// Result stage: select and sign-correct the result, output register and skid slot.
`default_nettype none

module i128d_post
    import i128d_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         tail_valid,
    input  wire i128d_work_t  tail_work,
    output logic              advance,
    i128d_rsp_if.source       rsp
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_res_reg;
    logic [WORD_W-1:0] out_res_next;
    logic              out_dz_reg;
    logic              out_dz_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [WORD_W-1:0] skid_res_reg;
    logic              skid_dz_reg;
    logic [WORD_W-1:0] sel_res;
    logic [WORD_W-1:0] tail_res;
    logic              out_free;
    logic              tail_in;

    // Hold the whole pipeline only while the skid slot is occupied.
    assign advance = ~skid_valid_reg;

    always_comb
    begin
        sel_res  = tail_work.want_rem ? tail_work.rem : tail_work.nq;
        tail_res = tail_work.neg_res ? (~sel_res + {{(WORD_W-1){1'b0}}, 1'b1}) : sel_res;
        out_free = ~out_valid_reg | rsp.ready;
        tail_in  = tail_valid & advance;

        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_dz_next     = out_dz_reg;
        skid_valid_next = skid_valid_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                out_dz_next     = skid_dz_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = tail_in;
                out_res_next   = tail_res;
                out_dz_next    = tail_work.dz;
            end
        end
        else if (tail_in)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        out_dz_reg  <= out_dz_next;
        if (~out_free & tail_in)
        begin
            skid_res_reg <= tail_res;
            skid_dz_reg  <= tail_work.dz;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_hi      = out_res_reg[WORD_W-1:HALF_W];
    assign rsp.result_lo      = out_res_reg[HALF_W-1:0];
    assign rsp.divide_by_zero = out_dz_reg;

    // Skid fills only when a held result blocks a delivered item.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !rsp.ready && tail_valid))
        else $error("skid slot filled while output was free");

    // Skid is never occupied behind an empty output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot valid with empty output register");

    // A taken output with a full skid is refilled from the skid next cycle.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && rsp.ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid slot did not drain into output register");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the pipelined 128-bit signed/unsigned integer divider.
`default_nettype none

module tb_top;
    import i128d_pkg::*;

    // Cycles with no item moved on either channel before the run is abandoned.
    // The pipeline is 130 deep, so a healthy run never comes close.
    localparam int unsigned STALL_LIMIT = 3000;
    // Quiet time after the last result, a little over the pipeline depth.
    localparam int unsigned DRAIN_CYCLES = 140;
    localparam int unsigned RANDOM_ITEMS = 760;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic [127:0] W_ZERO = 128'd0;
    localparam logic [127:0] W_ONE  = 128'd1;
    localparam logic [127:0] W_ONES = {128{1'b1}};
    localparam logic [127:0] W_MIN  = {1'b1, 127'd0};
    localparam logic [127:0] W_MAX  = {1'b0, {127{1'b1}}};

    typedef struct {
        i128d_mode_t  mode;
        logic [127:0] dividend;
        logic [127:0] divisor;
    } div_req_t;

    typedef struct {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
        logic        divide_by_zero;
    } div_rsp_t;

    // One directed row: the operation and, where it is obvious, the answer.
    typedef struct {
        i128d_mode_t  mode;
        logic [127:0] dividend;
        logic [127:0] divisor;
        logic         known;
        logic [127:0] result;
        logic         dz;
    } div_row_t;

    localparam int unsigned DIR_ROWS = 24;

    div_row_t dir_rows [DIR_ROWS] = '{
        // division by zero in every mode
        '{MODE_UDIV, W_ZERO,          W_ZERO, 1'b1, W_ONES,          1'b1},
        '{MODE_UREM, 128'h1234,       W_ZERO, 1'b1, 128'h1234,       1'b1},
        '{MODE_SDIV, -128'd5,         W_ZERO, 1'b1, W_ONE,           1'b1},
        '{MODE_SREM, -128'd5,         W_ZERO, 1'b1, -128'd5,         1'b1},
        '{MODE_SDIV, 128'd7,          W_ZERO, 1'b1, W_ONES,          1'b1},
        // most negative over minus one wraps
        '{MODE_SDIV, W_MIN,           W_ONES, 1'b1, W_MIN,           1'b0},
        '{MODE_SREM, W_MIN,           W_ONES, 1'b1, W_ZERO,          1'b0},
        // unsigned divisors at and above 2^127
        '{MODE_UDIV, W_ONES,          W_MIN,  1'b1, W_ONE,           1'b0},
        '{MODE_UREM, W_ONES,          W_MIN,  1'b1, W_MAX,           1'b0},
        '{MODE_UDIV, W_ONES,          W_ONES, 1'b1, W_ONE,           1'b0},
        // sign rules on small operands, then the extremes divided by one
        '{MODE_UDIV, 128'd7,          128'd2, 1'b1, 128'd3,          1'b0},
        '{MODE_UREM, 128'd7,          128'd2, 1'b1, W_ONE,           1'b0},
        '{MODE_SDIV, -128'd7,         128'd2, 1'b1, -128'd3,         1'b0},
        '{MODE_SREM, -128'd7,         128'd2, 1'b1, W_ONES,          1'b0},
        '{MODE_SDIV, 128'd7,         -128'd2, 1'b1, -128'd3,         1'b0},
        '{MODE_SREM, 128'd7,         -128'd2, 1'b1, W_ONE,           1'b0},
        '{MODE_SDIV, -128'd7,        -128'd2, 1'b1, 128'd3,          1'b0},
        '{MODE_SREM, -128'd7,        -128'd2, 1'b1, W_ONES,          1'b0},
        '{MODE_UDIV, W_MAX,           W_ONE,  1'b1, W_MAX,           1'b0},
        '{MODE_SDIV, W_MIN,           W_ONE,  1'b1, W_MIN,           1'b0},
        // the rest go through the predictor
        '{MODE_UDIV, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                     128'h0000_0000_0000_0001_0000_0000_0000_0000, 1'b0, W_ZERO, 1'b0},
        '{MODE_UREM, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                     128'h0000_0000_0000_0001_0000_0000_0000_0003, 1'b0, W_ZERO, 1'b0},
        '{MODE_SDIV, W_MIN,           W_MIN,  1'b0, W_ZERO,          1'b0},
        '{MODE_SREM, W_MAX,           W_MIN,  1'b0, W_ZERO,          1'b0}
    };

    logic clk;
    logic rst_n;

    i128d_req_if req_ch();
    i128d_rsp_if rsp_ch();

    int unsigned send_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    // Results still owed by the divider, oldest first.
    div_rsp_t owed_results [$];

    int128_divider_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Restoring long division on magnitudes with a 129-bit partial remainder,
    // then the sign rules of the signed modes.
    function automatic div_rsp_t divide_item(div_req_t it);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] pick;
        logic [128:0] part;
        logic         signed_op;
        logic         num_neg;
        logic         den_neg;
        int           i;
        div_rsp_t     r;

        num = it.dividend;
        den = it.divisor;
        quo = '0;
        part = '0;
        signed_op = (it.mode == MODE_SDIV) || (it.mode == MODE_SREM);
        num_neg = signed_op && num[127];
        den_neg = signed_op && den[127];
        if (num_neg)
        begin
            num = -num;
        end
        if (den_neg)
        begin
            den = -den;
        end
        for (i = 127; i >= 0; i--)
        begin
            part = {part[127:0], num[i]};
            if (part >= {1'b0, den})
            begin
                part = part - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        if ((it.mode == MODE_UREM) || (it.mode == MODE_SREM))
        begin
            pick = num_neg ? -part[127:0] : part[127:0];
        end
        else
        begin
            pick = (num_neg != den_neg) ? -quo : quo;
        end
        r.result_hi = pick[127:64];
        r.result_lo = pick[63:0];
        r.divide_by_zero = (it.divisor == '0);
        return r;
    endfunction

    // Operand mix: corners, small magnitudes of both signs, 64-bit values,
    // and plenty of fully random words so every bit toggles.
    function automatic logic [127:0] pick_operand();
        logic [127:0] w;

        w = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(11))
            0: w = W_ZERO;
            1: w = W_ONE;
            2: w = W_ONES;
            3: w = W_MIN;
            4: w = W_MAX;
            5: w = 128'($urandom_range(1, 1000));
            6: w = -128'($urandom_range(1, 1000));
            7: w = {64'd0, $urandom, $urandom};
            8: w = {{64{1'b1}}, 1'b1, 31'($urandom), $urandom};
            default: ;
        endcase
        return w;
    endfunction

    function automatic div_req_t pick_request();
        div_req_t it;

        it.mode = i128d_mode_t'($urandom_range(3));
        it.dividend = pick_operand();
        case ($urandom_range(19))
            0: it.divisor = W_ZERO;
            1, 2, 3, 4:
            begin
                // derive the divisor from the dividend so quotients stay nontrivial
                it.divisor = it.dividend >> $urandom_range(1, 126);
                if ($urandom_range(1))
                begin
                    it.divisor = -it.divisor;
                end
            end
            default: it.divisor = pick_operand();
        endcase
        return it;
    endfunction

    // Present one item at a falling edge, after any random idle time, and hold it until accepted,
    // then queue what the divider owes for it.
    task automatic send_item(input div_req_t it, input div_rsp_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= it.mode;
        req_ch.dividend_hi <= it.dividend[127:64];
        req_ch.dividend_lo <= it.dividend[63:0];
        req_ch.divisor_hi  <= it.divisor[127:64];
        req_ch.divisor_lo  <= it.divisor[63:0];
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        owed_results.push_back(want);
    endtask

    // Response side: toggle ready at falling edges per the current stall rate.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Check every result against the oldest owed one.
    always @(posedge clk)
    begin
        div_rsp_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected result: hi=%h lo=%h dz=%b",
                             rsp_ch.result_hi, rsp_ch.result_lo, rsp_ch.divide_by_zero);
                end
            end
            else
            begin
                want = owed_results.pop_front();
                if ((rsp_ch.result_hi !== want.result_hi) ||
                    (rsp_ch.result_lo !== want.result_lo) ||
                    (rsp_ch.divide_by_zero !== want.divide_by_zero))
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result mismatch: expected hi=%h lo=%h dz=%b, got hi=%h lo=%h dz=%b",
                                 want.result_hi, want.result_lo, want.divide_by_zero,
                                 rsp_ch.result_hi, rsp_ch.result_lo,
                                 rsp_ch.divide_by_zero);
                    end
                end
            end
        end
    end

    // Watchdog: drop the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        div_req_t    it;
        div_rsp_t    want;
        int unsigned phase;
        int unsigned n;

        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        rst_n = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_UDIV;
        req_ch.dividend_hi = '0;
        req_ch.dividend_lo = '0;
        req_ch.divisor_hi  = '0;
        req_ch.divisor_lo  = '0;

        // Hold reset, then release it away from the rising edge.
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows back to back at full rate.
        foreach (dir_rows[k])
        begin
            it.mode     = dir_rows[k].mode;
            it.dividend = dir_rows[k].dividend;
            it.divisor  = dir_rows[k].divisor;
            if (dir_rows[k].known)
            begin
                want.result_hi      = dir_rows[k].result[127:64];
                want.result_lo      = dir_rows[k].result[63:0];
                want.divide_by_zero = dir_rows[k].dz;
            end
            else
            begin
                want = divide_item(it);
            end
            send_item(it, want);
        end

        // Random items in four idling phases: none, sender idle, receiver
        // stalling, then both at a lighter rate. Rates change between items
        // only, so gaps land on every pipeline phase.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct = 18;
                    rsp_stall_pct = 18;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                it = pick_request();
                send_item(it, divide_item(it));
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain the pipeline, then wait out its depth to catch stray results.
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && owed_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/i128d_pkg.sv
rtl/core/i128d_ifs.sv
rtl/core/i128d_prep.sv
rtl/core/i128d_step.sv
rtl/core/i128d_post.sv
rtl/core/int128_divider_unit.sv
dv/tb_top.sv
